// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== sv/bsps_pkg.sv =====
// ----------------------------------------------------------------------------
// bsps_pkg
// types, status codes and pattern table for the body script pattern scanner
// ----------------------------------------------------------------------------
package bsps_pkg;

  localparam int unsigned WIN_DEPTH = 14;
  localparam int unsigned PAT_COUNT = 6;
  localparam int unsigned PAT_MAX   = WIN_DEPTH + 1;
  localparam logic [15:0] MAX_LENGTH_RST = 16'd4096;

  typedef logic [7:0] char_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_ZERO_BYTE = 2'd2,
    ST_INJECTION = 2'd3
  } status_t;

  // one beat moving from the input stage into the scan logic
  typedef struct packed {
    logic  go;
    logic  has_byte;
    logic  last;
    char_t value;
  } beat_t;

  // last character sits in the low byte
  localparam logic [PAT_MAX*8-1:0] PAT_TEXT [PAT_COUNT] = '{
    (PAT_MAX*8)'("<script"),
    (PAT_MAX*8)'("javascript:"),
    (PAT_MAX*8)'("onerror="),
    (PAT_MAX*8)'("onload="),
    (PAT_MAX*8)'("eval("),
    (PAT_MAX*8)'("document.cookie")
  };

  localparam int unsigned PAT_LEN [PAT_COUNT] = '{7, 11, 8, 7, 5, 15};

  function automatic char_t fold_case(input char_t c);
    char_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // seq[0] is the newest folded byte, seq[j] the one j bytes earlier
  function automatic logic pat_hit(input char_t seq [PAT_MAX]);
    logic any;
    logic ok;
    any = 1'b0;
    for (int p = 0; p < PAT_COUNT; p++) begin
      ok = 1'b1;
      for (int j = 0; j < PAT_MAX; j++) begin
        if (j < PAT_LEN[p] && seq[j] != PAT_TEXT[p][j*8 +: 8]) begin
          ok = 1'b0;
        end
      end
      any = any | ok;
    end
    return any;
  endfunction

endpackage

// ===== sv/bsps_matcher.sv =====
// ----------------------------------------------------------------------------
// bsps_matcher
// folded history window and parallel compare against the script patterns
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsps_matcher (
  input  logic            clk,
  input  logic            rst_n,
  input  bsps_pkg::beat_t beat,
  output logic            hit
);

  bsps_pkg::char_t win_r   [bsps_pkg::WIN_DEPTH];
  bsps_pkg::char_t win_nxt [bsps_pkg::WIN_DEPTH];
  bsps_pkg::char_t seq     [bsps_pkg::PAT_MAX];
  bsps_pkg::char_t cur;
  logic            clr;

  assign cur = bsps_pkg::fold_case(beat.value);
  assign clr = beat.go && beat.last;

  always_comb begin
    seq[0] = cur;
    for (int i = 0; i < bsps_pkg::WIN_DEPTH; i++) begin
      seq[i+1] = win_r[i];
    end
  end

  assign hit = beat.has_byte && bsps_pkg::pat_hit(seq);

  always_comb begin
    win_nxt = win_r;
    if (clr) begin
      for (int i = 0; i < bsps_pkg::WIN_DEPTH; i++) begin
        win_nxt[i] = '0;
      end
    end else if (beat.go && beat.has_byte) begin
      win_nxt[0] = cur;
      for (int i = 1; i < bsps_pkg::WIN_DEPTH; i++) begin
        win_nxt[i] = win_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bsps_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      win_r <= win_nxt;
    end
  end

  `ASSERT_NXT(a_win_cleared, clr,
    win_r[0] == '0 && win_r[bsps_pkg::WIN_DEPTH-1] == '0, "window not cleared at body end")
  `ASSERT_NXT(a_win_shift, beat.go && beat.has_byte && !beat.last,
    win_r[0] == $past(cur), "newest window byte wrong")

endmodule

// ===== sv/bsps_status.sv =====
// ----------------------------------------------------------------------------
// bsps_status
// length count, body flags, status priority and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsps_status #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bsps_pkg::beat_t        beat,
  input  logic                   hit,
  input  logic [LENGTH_BITS-1:0] limit,
  input  logic                   out_stall,
  output logic                   slot_free,
  output logic                   out_valid,
  output logic [1:0]             out_status
);

  logic [LENGTH_BITS:0] cnt_r, cnt_nxt, cnt_upd;
  logic                 zero_r, zero_nxt, zero_upd;
  logic                 pat_r, pat_nxt, pat_upd;
  logic                 out_valid_r, out_valid_nxt;
  bsps_pkg::status_t    status_r, status_nxt;
  logic                 done;

  assign done      = beat.go && beat.last;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cnt_upd  = cnt_r;
    zero_upd = zero_r;
    pat_upd  = pat_r;
    if (beat.has_byte) begin
      if (!cnt_r[LENGTH_BITS]) begin
        cnt_upd = cnt_r + (LENGTH_BITS+1)'(1);
      end
      zero_upd = zero_r | (beat.value == '0);
      pat_upd  = pat_r | hit;
    end

    if (cnt_upd > {1'b0, limit}) begin
      status_nxt = bsps_pkg::ST_TOO_LONG;
    end else if (zero_upd) begin
      status_nxt = bsps_pkg::ST_ZERO_BYTE;
    end else if (pat_upd) begin
      status_nxt = bsps_pkg::ST_INJECTION;
    end else begin
      status_nxt = bsps_pkg::ST_OK;
    end

    cnt_nxt  = cnt_r;
    zero_nxt = zero_r;
    pat_nxt  = pat_r;
    if (done) begin
      cnt_nxt  = '0;
      zero_nxt = 1'b0;
      pat_nxt  = 1'b0;
    end else if (beat.go) begin
      cnt_nxt  = cnt_upd;
      zero_nxt = zero_upd;
      pat_nxt  = pat_upd;
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      zero_r      <= 1'b0;
      pat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      zero_r      <= zero_nxt;
      pat_r       <= pat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

  `ASSERT_NXT(a_body_cleared, done,
    cnt_r == '0 && !zero_r && !pat_r, "body state not cleared after last beat")
  `ASSERT_NXT(a_result_loaded, done, out_valid_r, "last beat gave no result")
  `ASSERT_IMP(a_count_sat, cnt_r[LENGTH_BITS],
    cnt_r[LENGTH_BITS-1:0] == '0, "byte count ran past saturation")

endmodule

// ===== sv/body_script_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// body_script_pattern_scanner: input reg feeds scan logic and result reg, which
// gives the status; one beat per cycle, but a last beat waits on a stalled result
// synchronous active-low reset clears window, count, flags; max_length = 4096
// ----------------------------------------------------------------------------
module body_script_pattern_scanner #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_length
);

  logic                   s1_valid_r, s1_valid_nxt;
  bsps_pkg::char_t        s1_value_r;
  logic                   s1_has_r;
  logic                   s1_last_r;
  logic [15:0]            max_len_r;
  logic [LENGTH_BITS-1:0] limit;
  logic                   slot_free;
  logic                   go;
  logic                   accept;
  logic                   hit;
  bsps_pkg::beat_t        beat;

  assign cfg_ready = 1'b1;
  assign limit     = LENGTH_BITS'(max_len_r);

  assign go       = s1_valid_r && (!s1_last_r || slot_free);
  assign in_stall = s1_valid_r && !go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !go;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      max_len_r  <= bsps_pkg::MAX_LENGTH_RST;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_max_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= in_byte_value;
      s1_has_r   <= in_has_byte;
      s1_last_r  <= in_last;
    end
  end

  always_comb begin
    beat.go       = go;
    beat.has_byte = s1_has_r;
    beat.last     = s1_last_r;
    beat.value    = s1_value_r;
  end

  bsps_matcher u_matcher (
    .clk   (clk),
    .rst_n (rst_n),
    .beat  (beat),
    .hit   (hit)
  );

  bsps_status #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_status (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .hit        (hit),
    .limit      (limit),
    .out_stall  (out_stall),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

endmodule
